// ===== rtl/gdad_pkg.sv =====
// Shared types, widths and calendar helpers for the Gregorian date adder.
// No dependencies; used by every module of the block.
package gdad_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_IN_W = 14;
   // Internal year: start year plus the years a maximal day count can span.
   localparam int YEAR_W  = 15;
   localparam int LEFT_W  = 15;
   localparam int YMOD_W  = 9;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [YMOD_W-1:0] YMOD_LAST = 9'd399;
   localparam logic [YMOD_W-1:0] YMOD_C1   = 9'd100;
   localparam logic [YMOD_W-1:0] YMOD_C2   = 9'd200;
   localparam logic [YMOD_W-1:0] YMOD_C3   = 9'd300;

   // Working date while a word is being walked.
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [YMOD_W-1:0]  ymod;   // year mod 400
      logic [LEFT_W-1:0]  left;   // days still to add
   } date_type;

   // Leap year from the low year bits and year mod 400.
   function automatic logic is_leap(input logic [1:0] year_lo,
                                    input logic [YMOD_W-1:0] ymod);
      return (year_lo == 2'd0) &&
             (ymod != YMOD_C1) && (ymod != YMOD_C2) && (ymod != YMOD_C3);
   endfunction

   // Month length; zero for a month code outside 1..12.
   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         MONTH_FEB:                                 len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/gdad_mod400.sv =====
// Iterative year mod 400 unit: one restoring subtract step per cycle.
// Depends on gdad_pkg.
module gdad_mod400
   import gdad_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [YEAR_IN_W-1:0] year,
   output logic                 done,
   output logic [YMOD_W-1:0]    ymod
);

   // 400 << 5 exceeds half the 14-bit range, so six steps cover it.
   localparam int                STEPS = 6;
   localparam logic [2:0]        CNT_TOP = 3'(STEPS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [YEAR_IN_W-1:0] rem_ff, rem_in;
   logic [YEAR_W-1:0]    divisor;
   logic [YEAR_W-1:0]    rem_ext;

   assign divisor = YEAR_W'(400) << cnt_ff;
   assign rem_ext = YEAR_W'(rem_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_TOP;
         rem_in  = year;
      end else if (busy_ff) begin
         if (rem_ext >= divisor) begin
            rem_in = YEAR_IN_W'(rem_ext - divisor);
         end
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign ymod = YMOD_W'(rem_ff);

endmodule

// ===== rtl/gdad_month_step.sv =====
// Month-at-a-time advance: one compare and subtract against the room left
// in the current month. Combinational; depends on gdad_pkg.
module gdad_month_step
   import gdad_pkg::*;
(
   input  date_type cur,
   output date_type nxt,
   output logic     finish
);

   logic [DAY_W-1:0]  len;
   logic [DAY_W-1:0]  room;
   logic [LEFT_W-1:0] room_ext;

   assign len      = days_in(cur.month, is_leap(cur.year[1:0], cur.ymod));
   assign room     = len - cur.day;
   assign room_ext = LEFT_W'(room);
   assign finish   = (cur.left <= room_ext);

   always_comb begin
      nxt = cur;
      if (finish) begin
         nxt.day  = cur.day + DAY_W'(cur.left);
         nxt.left = '0;
      end else begin
         nxt.day  = 5'd1;
         nxt.left = cur.left - room_ext - LEFT_W'(1);
         if (cur.month == MONTH_DEC) begin
            nxt.month = MONTH_JAN;
            nxt.year  = cur.year + YEAR_W'(1);
            nxt.ymod  = (cur.ymod == YMOD_LAST) ? '0 : cur.ymod + YMOD_W'(1);
         end else begin
            nxt.month = cur.month + MONTH_W'(1);
         end
      end
   end

endmodule

// ===== rtl/gregorian_date_add_days_unit.sv =====
// Gregorian date adder. A request word carries a start date and a day count;
// the block answers with one response word holding the date that many days
// later, or the start date unchanged with bad_date set when the month is not
// 1..12 or the day lies outside that month. One word is worked on at a time:
// after acceptance a mod-400 reduction of the year runs (six subtract steps
// and a done strobe), then a validity check, then the walk moves one whole
// month per cycle through a single compare/subtract unit (a bad date skips
// the walk), then the output register is loaded once it is free. req_tready
// is high only while the sequencer is idle, which it may be while a finished
// response still waits in the output register.
module gregorian_date_add_days_unit
   import gdad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] start_day, [8:5] start_month, [22:9] start_year,
   // [37:23] days_to_add, [39:38] zero
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] end_day, [8:5] end_month, [22:9] end_year, [23] zero
   output logic [23:0] rsp_tdata,
   // [0] bad_date
   output logic [0:0]  rsp_tuser
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MOD   = 5'b00010,
      ST_CHECK = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   date_type         cur_ff, cur_in;
   logic             bad_ff, bad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [23:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_bad_ff, rsp_bad_in;

   logic             req_fire;
   logic             mod_done;
   logic [YMOD_W-1:0] mod_rem;
   date_type         step_nxt;
   logic             step_finish;
   logic [DAY_W-1:0] start_len;
   logic             start_bad;
   logic             out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Year mod 400 drives the century part of the leap rule.
   gdad_mod400 u_mod400 (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .year  (req_tdata[22:9]),
      .done  (mod_done),
      .ymod  (mod_rem)
   );

   gdad_month_step u_step (
      .cur    (cur_ff),
      .nxt    (step_nxt),
      .finish (step_finish)
   );

   // Start date check uses the month length for the start year.
   assign start_len = days_in(cur_ff.month, is_leap(cur_ff.year[1:0], cur_ff.ymod));
   assign start_bad = (start_len == '0) || (cur_ff.day == '0) || (cur_ff.day > start_len);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_in.day   = req_tdata[4:0];
               cur_in.month = req_tdata[8:5];
               cur_in.year  = YEAR_W'(req_tdata[22:9]);
               cur_in.ymod  = '0;
               cur_in.left  = req_tdata[37:23];
               state_in     = ST_MOD;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               cur_in.ymod = mod_rem;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            bad_in   = start_bad;
            state_in = start_bad ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            cur_in = step_nxt;
            if (step_finish) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, cur_ff.year[YEAR_IN_W-1:0], cur_ff.month, cur_ff.day};
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_bad_ff;

   // An accepted word always starts the year reduction.
   a_fire_to_mod: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MOD))
      else $error("accepted word did not enter year reduction");

   // The walk only ever sees a day inside its month.
   a_walk_day: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |->
         (cur_ff.day != '0) && (cur_ff.day <= start_len))
      else $error("walk day outside month");

   // A good response carries a real month.
   a_rsp_month: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bad_ff) |->
         (rsp_data_ff[8:5] >= MONTH_JAN) && (rsp_data_ff[8:5] <= MONTH_DEC))
      else $error("response month out of range");

   // The reduction finishes only while the sequencer waits for it.
   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_MOD))
      else $error("year reduction finished outside its state");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the Gregorian date adder (gregorian_date_add_days_unit).
// Depends on gdad_pkg and the block's RTL; it carries its own calendar predictor.
module tb_top
   import gdad_pkg::*;
;

   localparam int ITEMS_TOTAL   = 540;
   localparam int TAIL_CYCLES   = 1200;   // exceeds the worst walk
   localparam int REPORT_LIMIT  = 10;

   // Expected response word, one per request word.
   typedef struct {
      logic [DAY_W-1:0]     day;
      logic [MONTH_W-1:0]   month;
      logic [YEAR_IN_W-1:0] year;
      logic                 bad;
   } date_result_type;

   // Idling phases over the run.
   typedef enum int {
      PH_STEADY,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_LIGHT
   } idle_phase_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   logic [39:0]     date_words_q[$];     // request words not yet driven
   date_result_type dates_due_q[$];      // predicted responses, oldest first
   int              words_total    = 0;
   int              words_accepted = 0;
   int              mismatches     = 0;
   idle_phase_type  phase          = PH_STEADY;
   logic            req_taken      = 1'b0;

   gregorian_date_add_days_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Month length on the full year; zero for a month code outside 1..12.
   function automatic int unsigned month_length(int unsigned month, int unsigned year);
      int unsigned len;
      case (month)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11:           len = 30;
         MONTH_FEB: begin
            len = (((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0) ? 29 : 28;
         end
         default:               len = 0;
      endcase
      return len;
   endfunction

   // Date reached from the start date of a request word, walking month by month.
   function automatic date_result_type date_after(logic [39:0] word);
      int unsigned     day, month, year, left, len;
      date_result_type res;
      day   = word[4:0];
      month = word[8:5];
      year  = word[22:9];
      left  = word[37:23];
      len   = month_length(month, year);
      res.bad = (len == 0) || (day < 1) || (day > len);
      if (!res.bad) begin
         while (left > 0) begin
            len = month_length(month, year);
            if (left <= len - day) begin
               day  = day + left;
               left = 0;
            end else begin
               left  = left - (len - day + 1);
               day   = 1;
               month = month + 1;
               if (month > MONTH_DEC) begin
                  month = MONTH_JAN;
                  year  = year + 1;
               end
            end
         end
      end
      res.day   = day[DAY_W-1:0];
      res.month = month[MONTH_W-1:0];
      res.year  = year[YEAR_IN_W-1:0];   // wraps past 14 bits
      return res;
   endfunction

   // Request word layout: day, month, year, day count from bit 0 up.
   function automatic logic [39:0] pack_date(int unsigned day, int unsigned month,
                                             int unsigned year, int unsigned days);
      return {2'b00, days[14:0], year[13:0], month[3:0], day[4:0]};
   endfunction

   // Day count: mostly short walks, a few spanning the whole field.
   function automatic int unsigned rand_days();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10)      return 0;
      else if (pick < 60) return $urandom_range(400);
      else if (pick < 85) return $urandom_range(4000);
      else                return $urandom_range(32767);
   endfunction

   // Fill the request queue: directed corners, then random words.
   initial begin : stimulus
      int unsigned day, month, year, pick;
      // Extremes and rollovers.
      date_words_q.push_back(pack_date(1, 1, 0, 0));
      date_words_q.push_back(pack_date(31, 12, 9999, 32767));
      date_words_q.push_back(pack_date(31, 12, 16383, 32767));   // year wraps 14 bits
      date_words_q.push_back(pack_date(1, 1, 1, 16384));
      date_words_q.push_back(pack_date(30, 6, 2021, 0));
      date_words_q.push_back(pack_date(31, 1, 2021, 1));
      date_words_q.push_back(pack_date(31, 12, 1999, 1));
      date_words_q.push_back(pack_date(30, 11, 2021, 31));
      date_words_q.push_back(pack_date(1, 1, 2000, 366));
      // February under the 4/100/400 rule.
      date_words_q.push_back(pack_date(28, 2, 2023, 1));
      date_words_q.push_back(pack_date(28, 2, 2024, 1));
      date_words_q.push_back(pack_date(28, 2, 1900, 1));
      date_words_q.push_back(pack_date(28, 2, 2000, 1));
      date_words_q.push_back(pack_date(29, 2, 2000, 365));
      date_words_q.push_back(pack_date(1, 2, 2100, 60));
      // Invalid start dates.
      date_words_q.push_back(pack_date(29, 2, 2023, 5));
      date_words_q.push_back(pack_date(29, 2, 1900, 0));
      date_words_q.push_back(pack_date(31, 4, 2020, 10));
      date_words_q.push_back(pack_date(0, 5, 2020, 10));
      date_words_q.push_back(pack_date(15, 0, 2020, 10));
      date_words_q.push_back(pack_date(15, 13, 2020, 10));
      date_words_q.push_back(pack_date(31, 15, 16383, 32767));
      date_words_q.push_back(pack_date(0, 0, 0, 0));

      while (date_words_q.size() < ITEMS_TOTAL) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            // noise: raw fields, some of them invalid dates
            date_words_q.push_back(pack_date($urandom_range(31), $urandom_range(15),
                                             $urandom_range(16383), $urandom_range(32767)));
         end else begin
            if (pick < 22)      year = $urandom_range(16383);
            else if (pick < 35) year = $urandom_range(99) * 100 + $urandom_range(1) * 99;
            else                year = $urandom_range(9999);
            month = $urandom_range(12, 1);
            // favor month ends, where the rollovers live
            if ($urandom_range(3) == 0) day = month_length(month, year);
            else                        day = $urandom_range(month_length(month, year), 1);
            date_words_q.push_back(pack_date(day, month, year, rand_days()));
         end
      end
      words_total = date_words_q.size();
   end

   // Reset once, then wait for the run to drain.
   initial begin : sequencer
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (words_accepted < words_total || dates_due_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: several times the slowest correct run.
   initial begin : watchdog
      #12_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Request driver: holds a word until taken, idles per phase.
   always @(negedge clock) begin : req_driver
      logic idle;
      idle = 1'b0;
      if (phase == PH_SEND_IDLE)  idle = ($urandom_range(99) < 74);
      if (phase == PH_BOTH_LIGHT) idle = ($urandom_range(99) < 13);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // word still pending, hold it
      end else if (date_words_q.size() != 0 && !idle) begin
         req_tvalid <= 1'b1;
         req_tdata  <= date_words_q.pop_front();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response backpressure.
   always @(negedge clock) begin : rsp_driver
      case (phase)
         PH_RECV_STALL: rsp_tready <= ($urandom_range(99) >= 74);
         PH_BOTH_LIGHT: rsp_tready <= ($urandom_range(99) >= 13);
         default:       rsp_tready <= 1'b1;
      endcase
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin : monitor
      date_result_type due;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         dates_due_q.push_back(date_after(req_tdata));
         words_accepted = words_accepted + 1;
         phase = idle_phase_type'((words_accepted * 4) / ITEMS_TOTAL > 3 ?
                                  3 : (words_accepted * 4) / ITEMS_TOTAL);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (dates_due_q.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response word: data %h user %b", rsp_tdata, rsp_tuser);
         end else begin
            due = dates_due_q.pop_front();
            if (rsp_tdata[4:0] !== due.day || rsp_tdata[8:5] !== due.month ||
                rsp_tdata[22:9] !== due.year || rsp_tuser[0] !== due.bad ||
                rsp_tdata[23] !== 1'b0) begin
               mismatches = mismatches + 1;
               if (mismatches <= REPORT_LIMIT)
                  $display("date mismatch: expected %0d/%0d/%0d bad %b, got %0d/%0d/%0d bad %b",
                           due.day, due.month, due.year, due.bad,
                           rsp_tdata[4:0], rsp_tdata[8:5], rsp_tdata[22:9], rsp_tuser[0]);
            end
         end
      end
   end

endmodule
